### sv/gbfs_pkg.sv
// Shared types and codes for the graph reachability unit.
`default_nettype none

package gbfs_pkg;

    localparam int LABEL_W = 16;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               op;
        logic [LABEL_W-1:0] node_a;
        logic [LABEL_W-1:0] node_b;
    } t_item;

    typedef struct packed {
        logic reachable;
        logic status;
    } t_result;

endpackage

`default_nettype wire

### sv/graph_bfs_reachability_unit.sv
// Graph reachability unit: label table, adjacency matrix and breadth-first search sequencer.
//
// Usage: drive i_item and raise start while busy is low; the item is taken at that edge
// and busy stays high until it is finished. Exactly one result follows every item: it sits
// on o_result for a single cycle with o_strobe high, and the receiver cannot hold it off.
// A new item may be started in the strobe cycle itself.
// Every item first scans the label table one entry a cycle through its read port. An
// add-edge then writes any new labels and does a read-modify-write of the adjacency rows,
// of one row only for a self loop. A query expands one node per cycle from the adjacency
// memory's single read port while the current group of up to 32 nodes of the pending set
// holds one; empty groups are skipped in turn.
// The strobe is registered and rises in the cycle after the last busy cycle's decision.
// Reset (synchronous, active low) empties the label table and the graph: the
// slot count is cleared and a row is rewritten whole when its slot is first allocated, so
// no clearing pass is needed.
`default_nettype none

module graph_bfs_reachability_unit #(
    parameter int MAX_NODES = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire gbfs_pkg::t_item  i_item,
    output logic                  busy,
    output logic                  o_strobe,
    output gbfs_pkg::t_result     o_result
);

    localparam int SW   = $clog2(MAX_NODES);
    localparam int CNTW = $clog2(MAX_NODES + 1);
    localparam int CW   = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int NCH  = (MAX_NODES + CW - 1) / CW;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * CW;
    localparam int PEW  = $clog2(CW);
    localparam int IW   = $clog2(PADW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOK   = 4'd1;
    localparam logic [3:0] S_LAB_A  = 4'd2;
    localparam logic [3:0] S_LAB_B  = 4'd3;
    localparam logic [3:0] S_RD_A   = 4'd4;
    localparam logic [3:0] S_WR_A   = 4'd5;
    localparam logic [3:0] S_RD_B   = 4'd6;
    localparam logic [3:0] S_WR_B   = 4'd7;
    localparam logic [3:0] S_SEARCH = 4'd8;

    // memories
    logic [gbfs_pkg::LABEL_W-1:0] m_labels [MAX_NODES];
    logic [MAX_NODES-1:0]         m_adj    [MAX_NODES];
    logic [gbfs_pkg::LABEL_W-1:0] r_lab_q;
    logic [MAX_NODES-1:0]         r_row_q;

    // control
    logic [3:0]      r_state,    n_state;
    logic [CNTW-1:0] r_count,    n_count;
    logic            r_cmp_v,    n_cmp_v;
    logic            r_inflight, n_inflight;
    logic            r_out_valid, n_out_valid;

    // payload
    gbfs_pkg::t_item   r_item,    n_item;
    gbfs_pkg::t_result r_out,     n_out;
    logic [CNTW-1:0]   r_scan,    n_scan;
    logic [SW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_fa,      n_fa;
    logic              r_fb,      n_fb;
    logic [SW-1:0]     r_sa,      n_sa;
    logic [SW-1:0]     r_sb,      n_sb;
    logic              r_new_a,   n_new_a;
    logic              r_new_b,   n_new_b;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [PADW-1:0]   r_pending, n_pending;
    logic [CHW-1:0]    r_cursor,  n_cursor;

    // memory ports
    logic                         lab_we;
    logic [SW-1:0]                lab_waddr;
    logic [gbfs_pkg::LABEL_W-1:0] lab_wdata;
    logic [SW-1:0]                lab_raddr;
    logic                         adj_we;
    logic [SW-1:0]                adj_waddr;
    logic [MAX_NODES-1:0]         adj_wdata;
    logic [SW-1:0]                adj_raddr;

    // lookup and search datapath
    logic              issuing;
    logic              look_done;
    logic              same_label;
    logic              need_a;
    logic              need_b;
    logic [CNTW:0]     count_need;
    logic [CW-1:0]     cur_chunk;
    logic [CW-1:0]     low_oh;
    logic              pick;
    logic [PEW-1:0]    pe_idx;
    logic [IW-1:0]     pick_full;
    logic [SW-1:0]     pick_node;
    logic [PADW-1:0]   clr_mask;
    logic [MAX_NODES-1:0] new_bits;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    assign issuing    = (r_scan < r_count);
    assign look_done  = !issuing && !r_cmp_v;
    assign lab_raddr  = issuing ? r_scan[SW-1:0] : '0;
    assign same_label = (r_item.node_a == r_item.node_b);
    assign need_a     = !r_fa;
    assign need_b     = !r_fb && !same_label;
    assign count_need = {1'b0, r_count} + (CNTW+1)'(need_a) + (CNTW+1)'(need_b);

    // pending set is walked one group of up to 32 nodes at a time, lowest node first
    assign cur_chunk = r_pending[r_cursor*CW +: CW];
    assign low_oh    = cur_chunk & (~cur_chunk + 1'b1);
    assign pick      = |cur_chunk;
    assign pick_full = IW'(IW'(r_cursor) * IW'(CW)) + IW'(pe_idx);
    assign pick_node = pick_full[SW-1:0];
    assign new_bits  = r_inflight ? (r_row_q & ~r_visited) : '0;

    always_comb begin
        pe_idx = '0;
        for (int i = CW - 1; i >= 0; i--) begin
            if (cur_chunk[i]) begin
                pe_idx = PEW'(i);
            end
        end
    end

    always_comb begin
        clr_mask = '0;
        for (int j = 0; j < NCH; j++) begin
            if (pick && (r_cursor == CHW'(j))) begin
                clr_mask[j*CW +: CW] = low_oh;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmp_v     = 1'b0;
        n_inflight  = 1'b0;
        n_out_valid = 1'b0;
        n_item      = r_item;
        n_out       = r_out;
        n_scan      = r_scan;
        n_cmp_idx   = r_cmp_idx;
        n_fa        = r_fa;
        n_fb        = r_fb;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_new_a     = r_new_a;
        n_new_b     = r_new_b;
        n_visited   = r_visited;
        n_pending   = r_pending;
        n_cursor    = r_cursor;
        lab_we      = 1'b0;
        lab_waddr   = r_sa;
        lab_wdata   = r_item.node_a;
        adj_we      = 1'b0;
        adj_waddr   = r_sa;
        adj_wdata   = '0;
        adj_raddr   = r_sa;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_scan  = '0;
                    n_fa    = 1'b0;
                    n_fb    = 1'b0;
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                if (issuing) begin
                    n_scan    = r_scan + 1'b1;
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_scan[SW-1:0];
                end
                if (r_cmp_v) begin
                    if (r_lab_q == r_item.node_a) begin
                        n_fa = 1'b1;
                        n_sa = r_cmp_idx;
                    end
                    if (r_lab_q == r_item.node_b) begin
                        n_fb = 1'b1;
                        n_sb = r_cmp_idx;
                    end
                end
                if (look_done) begin
                    n_out = '0;
                    if (r_item.op == gbfs_pkg::OP_ADD_EDGE) begin
                        if (count_need > (CNTW+1)'(MAX_NODES)) begin
                            n_out.status = gbfs_pkg::STATUS_FULL;
                            n_out_valid  = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_new_a = need_a;
                            n_new_b = need_b;
                            if (need_a) begin
                                n_sa = r_count[SW-1:0];
                            end
                            if (same_label) begin
                                n_sb = need_a ? r_count[SW-1:0] : r_sa;
                            end else if (need_b) begin
                                n_sb = SW'(r_count + CNTW'(need_a));
                            end
                            n_state = S_LAB_A;
                        end
                    end else if (same_label) begin
                        n_out.reachable = 1'b1;
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end else if (!(r_fa && r_fb)) begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_visited = MAX_NODES'(1) << r_sa;
                        n_pending = PADW'(1) << r_sa;
                        n_cursor  = '0;
                        n_state   = S_SEARCH;
                    end
                end
            end

            S_LAB_A: begin
                lab_we    = r_new_a;
                lab_waddr = r_sa;
                lab_wdata = r_item.node_a;
                n_state   = S_LAB_B;
            end

            S_LAB_B: begin
                lab_we    = r_new_b;
                lab_waddr = r_sb;
                lab_wdata = r_item.node_b;
                n_count   = r_count + CNTW'(r_new_a) + CNTW'(r_new_b);
                n_state   = S_RD_A;
            end

            S_RD_A: begin
                adj_raddr = r_sa;
                n_state   = S_WR_A;
            end

            S_WR_A: begin
                // a freshly allocated row holds stale data, so it is rewritten whole
                adj_we    = 1'b1;
                adj_waddr = r_sa;
                adj_wdata = (r_new_a ? '0 : r_row_q) | (MAX_NODES'(1) << r_sb);
                if (same_label) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_RD_B;
                end
            end

            S_RD_B: begin
                adj_raddr = r_sb;
                n_state   = S_WR_B;
            end

            S_WR_B: begin
                adj_we      = 1'b1;
                adj_waddr   = r_sb;
                adj_wdata   = (r_new_b ? '0 : r_row_q) | (MAX_NODES'(1) << r_sa);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            S_SEARCH: begin
                adj_raddr  = pick_node;
                n_inflight = pick;
                n_visited  = r_visited | new_bits;
                n_pending  = (r_pending & ~clr_mask) | PADW'(new_bits);
                if (!pick) begin
                    n_cursor = (r_cursor == CHW'(NCH - 1)) ? '0 : r_cursor + 1'b1;
                end
                // anything marked visited is bound to be popped, so finish early
                if (r_visited[r_sb]) begin
                    n_out.reachable = 1'b1;
                    n_out_valid     = 1'b1;
                    n_inflight      = 1'b0;
                    n_state         = S_IDLE;
                end else if (!(|r_pending) && !r_inflight) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_v     <= 1'b0;
            r_inflight  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_v     <= n_cmp_v;
            r_inflight  <= n_inflight;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_out     <= n_out;
        r_scan    <= n_scan;
        r_cmp_idx <= n_cmp_idx;
        r_fa      <= n_fa;
        r_fb      <= n_fb;
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_new_a   <= n_new_a;
        r_new_b   <= n_new_b;
        r_visited <= n_visited;
        r_pending <= n_pending;
        r_cursor  <= n_cursor;
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            m_labels[lab_waddr] <= lab_wdata;
        end
        r_lab_q <= m_labels[lab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            m_adj[adj_waddr] <= adj_wdata;
        end
        r_row_q <= m_adj[adj_raddr];
    end

endmodule

`default_nettype wire

### sv/gbfs_checker.sv
// Port-level checks for the graph reachability unit, bound to the top level.
`default_nettype none

module gbfs_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_strobe,
    input wire gbfs_pkg::t_result o_result
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a transfer in");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("result strobed in the cycle after a transfer in");

    a_strobe_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && $past(busy))
        else $error("result strobe not at the end of a busy period");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.reachable && o_result.status))
        else $error("reachable and table-full reported together");

endmodule

bind graph_bfs_reachability_unit gbfs_checker u_gbfs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the graph reachability unit: edge adds and BFS queries.
`default_nettype none

module testbench;

    localparam int GRAPH_NODES = 64;
    localparam int POOL_SIZE   = 100;
    localparam int RAND_ITEMS  = 450;

    // Mirror of the label table and adjacency matrix; predicts one result per transfer
    class reach_scoreboard;
        logic [gbfs_pkg::LABEL_W-1:0] labels[GRAPH_NODES];
        int                           used_slots;
        logic [GRAPH_NODES-1:0]       adj_rows[GRAPH_NODES];
        gbfs_pkg::t_result            expected_q[$];
        int                           errors;

        function new();
            used_slots = 0;
            errors     = 0;
            foreach (adj_rows[i]) adj_rows[i] = '0;
        endfunction

        function int slot_of(logic [gbfs_pkg::LABEL_W-1:0] lab);
            for (int i = 0; i < used_slots; i++)
                if (labels[i] == lab) return i;
            return -1;
        endfunction

        function logic connected(int from, int to);
            logic [GRAPH_NODES-1:0] seen;
            logic [GRAPH_NODES-1:0] prev;
            seen = '0;
            seen[from] = 1'b1;
            do begin
                prev = seen;
                for (int k = 0; k < GRAPH_NODES; k++)
                    if (seen[k]) seen |= adj_rows[k];
            end while (seen != prev);
            return seen[to];
        endfunction

        function void note_item(gbfs_pkg::t_item it);
            gbfs_pkg::t_result res;
            int                sa;
            int                sb;
            int                need;
            res = '{reachable: 1'b0, status: gbfs_pkg::STATUS_OK};
            sa  = slot_of(it.node_a);
            sb  = slot_of(it.node_b);
            if (it.op == gbfs_pkg::OP_ADD_EDGE) begin
                need = (sa < 0 ? 1 : 0) + ((sb < 0 && it.node_b != it.node_a) ? 1 : 0);
                if (used_slots + need > GRAPH_NODES) begin
                    res.status = gbfs_pkg::STATUS_FULL;
                end else begin
                    if (sa < 0) begin
                        sa = used_slots;
                        labels[used_slots] = it.node_a;
                        used_slots++;
                    end
                    if (it.node_b == it.node_a) begin
                        sb = sa;
                    end else if (sb < 0) begin
                        sb = used_slots;
                        labels[used_slots] = it.node_b;
                        used_slots++;
                    end
                    adj_rows[sa][sb] = 1'b1;
                    adj_rows[sb][sa] = 1'b1;
                end
            end else if (it.node_a == it.node_b) begin
                res.reachable = 1'b1;
            end else if (sa >= 0 && sb >= 0) begin
                res.reachable = connected(sa, sb);
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(gbfs_pkg::t_result got);
            gbfs_pkg::t_result exp_res;
            if (expected_q.size() == 0) begin
                $error("result with nothing outstanding: reachable %0b status %0b",
                       got.reachable, got.status);
                errors++;
                return;
            end
            exp_res = expected_q[0];
            expected_q.delete(0);
            if (got.reachable !== exp_res.reachable) begin
                $error("reachable mismatch: expected %0b, got %0b",
                       exp_res.reachable, got.reachable);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $error("status mismatch: expected %0b, got %0b", exp_res.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    gbfs_pkg::t_item   i_item;
    logic              busy;
    logic              o_strobe;
    gbfs_pkg::t_result o_result;

    reach_scoreboard              reach_sb;
    logic [gbfs_pkg::LABEL_W-1:0] label_pool[POOL_SIZE];

    graph_bfs_reachability_unit #(.MAX_NODES(GRAPH_NODES)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) reach_sb.check_result(o_result);
    end

    // start is left high after a transfer so back-to-back items keep it asserted
    task automatic send_item(input logic op, input logic [gbfs_pkg::LABEL_W-1:0] a,
                             input logic [gbfs_pkg::LABEL_W-1:0] b);
        gbfs_pkg::t_item it;
        it = '{op: op, node_a: a, node_b: b};
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        reach_sb.note_item(it);
    endtask

    task automatic idle_burst(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_all_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (reach_sb.pending() != 0) @(posedge i_clk);
    endtask

    // mostly labels from a pool so the graph grows connected; now and then a stray label
    function automatic logic [gbfs_pkg::LABEL_W-1:0] pick_label(input int span);
        if ($urandom_range(0, 15) == 0)
            return gbfs_pkg::LABEL_W'($urandom_range(0, 65535));
        return label_pool[$urandom_range(0, span - 1)];
    endfunction

    initial begin
        logic                         op;
        logic [gbfs_pkg::LABEL_W-1:0] a;
        logic [gbfs_pkg::LABEL_W-1:0] b;
        int                           span;

        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        reach_sb = new();
        label_pool[0] = '0;
        label_pool[1] = '1;
        label_pool[2] = 16'h5555;
        label_pool[3] = 16'hAAAA;
        for (int i = 4; i < POOL_SIZE; i++)
            label_pool[i] = gbfs_pkg::LABEL_W'($urandom_range(0, 65535));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, self loop, duplicates, unknown and equal labels
        send_item(gbfs_pkg::OP_QUERY,    16'hBEEF, 16'hBEEF);
        send_item(gbfs_pkg::OP_QUERY,    16'h0000, 16'hFFFF);
        send_item(gbfs_pkg::OP_ADD_EDGE, 16'h0000, 16'hFFFF);
        send_item(gbfs_pkg::OP_QUERY,    16'h0000, 16'hFFFF);
        send_item(gbfs_pkg::OP_QUERY,    16'hFFFF, 16'h0000);
        send_item(gbfs_pkg::OP_ADD_EDGE, 16'h1234, 16'h1234);
        send_item(gbfs_pkg::OP_QUERY,    16'h1234, 16'h1234);
        send_item(gbfs_pkg::OP_QUERY,    16'h0000, 16'h1234);
        send_item(gbfs_pkg::OP_QUERY,    16'h5555, 16'h0000);
        send_item(gbfs_pkg::OP_QUERY,    16'h0000, 16'h5555);
        send_item(gbfs_pkg::OP_ADD_EDGE, 16'hFFFF, 16'h0000);
        send_item(gbfs_pkg::OP_ADD_EDGE, 16'hFFFF, 16'h1234);
        send_item(gbfs_pkg::OP_QUERY,    16'h0000, 16'h1234);
        send_item(gbfs_pkg::OP_ADD_EDGE, 16'h5555, 16'hAAAA);
        send_item(gbfs_pkg::OP_QUERY,    16'hAAAA, 16'h1234);
        send_item(gbfs_pkg::OP_ADD_EDGE, 16'hAAAA, 16'h1234);
        send_item(gbfs_pkg::OP_QUERY,    16'h5555, 16'h0000);
        send_item(gbfs_pkg::OP_QUERY,    16'h0000, 16'h0000);
        wait_all_done();

        // first a modest label pool, then a wide one that fills the table
        for (int n = 0; n < RAND_ITEMS; n++) begin
            span = (n < 250) ? 45 : POOL_SIZE;
            op   = ($urandom_range(0, 1) == 0) ? gbfs_pkg::OP_ADD_EDGE : gbfs_pkg::OP_QUERY;
            a    = pick_label(span);
            b    = ($urandom_range(0, 9) == 0) ? a : pick_label(span);
            send_item(op, a, b);
            if (n < 390 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 10));
            if (n == 200) wait_all_done();
        end

        wait_all_done();
        repeat (300) @(posedge i_clk);
        if (reach_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

### graph_bfs_reachability_unit.f
sv/gbfs_pkg.sv
sv/graph_bfs_reachability_unit.sv
sv/gbfs_checker.sv
tb/testbench.sv
